FILE: hdl/h264nal_pkg.sv
// shared types, constants and the element kind table of the nal header parser
`default_nettype none
package h264nal_pkg;

  localparam int unsigned MAX_POC_CYCLE    = 255;
  localparam int unsigned MAX_GOLOMB_ZEROS = 31;

  localparam logic [31:0] START_WORD   = 32'h0000_0001;
  localparam logic [7:0]  HIGH_PROFILE = 8'd100;
  localparam logic [4:0]  AUD_TYPE     = 5'd9;
  localparam logic [4:0]  SPS_TYPE     = 5'd7;
  localparam logic [5:0]  NUM_IDS      = 6'd41;
  localparam logic [5:0]  KIND_UE      = 6'd32;
  localparam logic [5:0]  KIND_SE      = 6'd33;

  // element ids
  localparam logic [5:0] ID_START      = 6'd0;
  localparam logic [5:0] ID_FORBIDDEN  = 6'd1;
  localparam logic [5:0] ID_REF_IDC    = 6'd2;
  localparam logic [5:0] ID_UNIT_TYPE  = 6'd3;
  localparam logic [5:0] ID_PROFILE    = 6'd4;
  localparam logic [5:0] ID_SPS_ID     = 6'd11;
  localparam logic [5:0] ID_CHROMA     = 6'd12;
  localparam logic [5:0] ID_LOG2_FN    = 6'd17;
  localparam logic [5:0] ID_POC_TYPE   = 6'd18;
  localparam logic [5:0] ID_LOG2_POC   = 6'd19;
  localparam logic [5:0] ID_DELTA_ZERO = 6'd20;
  localparam logic [5:0] ID_NUM_CYCLE  = 6'd23;
  localparam logic [5:0] ID_OFFSET_REF = 6'd24;
  localparam logic [5:0] ID_NUM_REF    = 6'd25;
  localparam logic [5:0] ID_FRAME_MBS  = 6'd29;
  localparam logic [5:0] ID_MB_AFF     = 6'd30;
  localparam logic [5:0] ID_DIRECT_8X8 = 6'd31;
  localparam logic [5:0] ID_CROPPING   = 6'd32;
  localparam logic [5:0] ID_CROP_LEFT  = 6'd33;
  localparam logic [5:0] ID_VUI        = 6'd37;
  localparam logic [5:0] ID_FIRST_MB   = 6'd38;
  localparam logic [5:0] ID_PPS_ID     = 6'd40;

  // error codes
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_START   = 2'd1;
  localparam logic [1:0] ERR_GOLOMB  = 2'd2;
  localparam logic [1:0] ERR_UNKNOWN = 2'd3;

  typedef enum logic [2:0] {
    M_EXPECT = 3'd0,
    M_HEADER = 3'd1,
    M_SPS    = 3'd2,
    M_SLICE  = 3'd3,
    M_SEARCH = 3'd4,
    M_SKIP   = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    C_IDLE  = 2'd0,
    C_WORK  = 2'd1,
    C_FLUSH = 2'd2
  } ctl_state_t;

  typedef struct packed {
    logic       load;
    logic       step;
    logic       flush;
    logic [2:0] cnt;
  } dp_cmd_t;

  typedef struct packed {
    logic res;
    logic last_step;
    logic pend_v;
    logic out_free;
  } dp_status_t;

  // bit count of a fixed field, or KIND_UE / KIND_SE
  function automatic logic [5:0] elem_kind(input logic [5:0] id);
    logic [5:0] k;
    k = KIND_UE;
    case (id)
      6'd0:  k = 6'd32;
      6'd1:  k = 6'd1;
      6'd2:  k = 6'd2;
      6'd3:  k = 6'd5;
      6'd4:  k = 6'd8;
      6'd5, 6'd6, 6'd7, 6'd8: k = 6'd1;
      6'd9:  k = 6'd4;
      6'd10: k = 6'd8;
      6'd15, 6'd16, 6'd20, 6'd26, 6'd29, 6'd30, 6'd31, 6'd32, 6'd37: k = 6'd1;
      6'd21, 6'd22, 6'd24: k = KIND_SE;
      default: k = KIND_UE;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/h264_nal_header_parser.sv
// top level of the annex-b nal header, sps and slice header parser
// Each accepted word is one stream byte; the block takes it, works on it and is
// ready again only after its flush, so no new byte is taken while one is in
// work. The nal header byte gives three results, and for sps and slice bytes
// the exp-golomb reader consumes one bit per clock while no stall holds it. A
// byte that ends the unit early finishes sooner. Results go through a one-word
// pending slot and an output register, so a stalled output side holds the
// parser only when both are full. in_tlast marks the final byte of the buffer
// and returns the parser to expecting a start code.
`default_nettype none
module h264_nal_header_parser (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [7:0]  in_tdata,   // in_byte[7:0]
  input  wire         in_tlast,   // stream_end
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [55:0] out_tdata,  // element_id[5:0], element_value[38:6],
                                  // element_index[46:39], error_code[48:47], zeros
  output logic [4:0]  out_tuser,  // nal_kind[4:0]
  output logic        out_tlast   // last_of_run
);
  import h264nal_pkg::*;

  dp_cmd_t     cmd;
  dp_status_t  st;
  logic [5:0]  element_id;
  logic [32:0] element_value;
  logic [7:0]  element_index;
  logic [1:0]  error_code;

  h264nal_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .st        (st),
    .cmd       (cmd)
  );

  h264nal_dp u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .st      (st),
    .in_byte (in_tdata),
    .in_end  (in_tlast),
    .out_v   (out_tvalid),
    .out_rdy (out_tready),
    .o_id    (element_id),
    .o_val   (element_value),
    .o_idx   (element_index),
    .o_kind  (out_tuser),
    .o_err   (error_code),
    .o_last  (out_tlast)
  );

  assign out_tdata = {7'd0, error_code, element_index, element_value, element_id};

endmodule
`default_nettype wire

FILE: hdl/h264nal_ctrl.sv
// controller: sequences the steps of one stream word and the final flush
`default_nettype none
module h264nal_ctrl (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_tvalid,
  output logic                     in_tready,
  input  h264nal_pkg::dp_status_t  st,
  output h264nal_pkg::dp_cmd_t     cmd
);
  import h264nal_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      cnt_r   <= 3'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    in_tready = 1'b0;
    cmd.load  = 1'b0;
    cmd.step  = 1'b0;
    cmd.flush = 1'b0;
    cmd.cnt   = cnt_r;
    case (state_r)
      C_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = 3'd0;
          state_nxt = C_WORK;
        end
      end
      C_WORK: begin
        // a result may only go out when the pending slot can move on
        if (!(st.res && st.pend_v) || st.out_free) begin
          cmd.step = 1'b1;
          if (st.last_step) begin
            state_nxt = C_FLUSH;
          end else begin
            cnt_nxt = cnt_r + 3'd1;
          end
        end
      end
      C_FLUSH: begin
        if (!st.pend_v || st.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = C_IDLE;
        end
      end
      default: state_nxt = C_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/h264nal_dp.sv
// datapath: parse state, bit-serial exp-golomb reader, pending and output words
`default_nettype none
module h264nal_dp (
  input  wire                      clk,
  input  wire                      rst_n,
  input  h264nal_pkg::dp_cmd_t     cmd,
  output h264nal_pkg::dp_status_t  st,
  input  wire  [7:0]               in_byte,
  input  wire                      in_end,
  output logic                     out_v,
  input  wire                      out_rdy,
  output logic [5:0]               o_id,
  output logic [32:0]              o_val,
  output logic [7:0]               o_idx,
  output logic [4:0]               o_kind,
  output logic [1:0]               o_err,
  output logic                     o_last
);
  import h264nal_pkg::*;

  mode_t       mode_r, mode_nxt;
  logic [5:0]  step_r, step_nxt;
  logic [31:0] win_r, win_nxt;
  logic [32:0] acc_r, acc_nxt;
  logic [5:0]  taken_r, taken_nxt;
  logic [5:0]  zc_r, zc_nxt;
  logic [4:0]  utype_r, utype_nxt;
  logic [7:0]  prof_r, prof_nxt;
  logic [1:0]  poc_r, poc_nxt;
  logic [7:0]  crem_r, crem_nxt;
  logic [7:0]  cidx_r, cidx_nxt;
  logic [1:0]  flags_r, flags_nxt;
  logic [7:0]  byte_r;
  logic        end_r;

  logic        res_v;
  logic [5:0]  res_id;
  logic [32:0] res_val;
  logic [7:0]  res_idx;
  logic [4:0]  res_kind;
  logic [1:0]  res_err;
  logic        last_step;

  logic        pend_v_r;
  logic [5:0]  pend_id_r;
  logic [32:0] pend_val_r;
  logic [7:0]  pend_idx_r;
  logic [4:0]  pend_kind_r;
  logic [1:0]  pend_err_r;

  logic        out_v_r;
  logic [5:0]  out_id_r;
  logic [32:0] out_val_r;
  logic [7:0]  out_idx_r;
  logic [4:0]  out_kind_r;
  logic [1:0]  out_err_r;
  logic        out_last_r;
  logic        out_free;

  assign out_free     = !out_v_r || out_rdy;
  assign st.res       = res_v;
  assign st.last_step = last_step;
  assign st.pend_v    = pend_v_r;
  assign st.out_free  = out_free;

  assign out_v  = out_v_r;
  assign o_id   = out_id_r;
  assign o_val  = out_val_r;
  assign o_idx  = out_idx_r;
  assign o_kind = out_kind_r;
  assign o_err  = out_err_r;
  assign o_last = out_last_r;

  always_comb begin
    logic        bit_in;
    logic [5:0]  kind;
    logic [31:0] win_sh;
    logic [32:0] acc_sh;
    logic [32:0] code;
    logic [5:0]  taken_inc;
    logic [5:0]  zc_inc;
    logic        cmp_en;
    logic [32:0] cmp_val;
    logic        srch;
    logic [6:0]  nxt_id;
    logic [4:0]  t;
    logic [7:0]  crem_dec;

    mode_nxt  = mode_r;
    step_nxt  = step_r;
    win_nxt   = win_r;
    acc_nxt   = acc_r;
    taken_nxt = taken_r;
    zc_nxt    = zc_r;
    utype_nxt = utype_r;
    prof_nxt  = prof_r;
    poc_nxt   = poc_r;
    crem_nxt  = crem_r;
    cidx_nxt  = cidx_r;
    flags_nxt = flags_r;

    res_v    = 1'b0;
    res_id   = step_r;
    res_val  = '0;
    res_idx  = '0;
    res_kind = utype_r;
    res_err  = ERR_NONE;

    bit_in    = byte_r[3'd7 - cmd.cnt];
    kind      = elem_kind(step_r);
    win_sh    = {win_r[23:0], byte_r};
    acc_sh    = {acc_r[31:0], bit_in};
    code      = acc_sh - 33'd1;
    taken_inc = taken_r + 6'd1;
    zc_inc    = zc_r + 6'd1;
    cmp_en    = 1'b0;
    cmp_val   = '0;
    srch      = 1'b0;
    nxt_id    = {1'b0, step_r} + 7'd1;
    t         = byte_r[4:0];
    crem_dec  = (crem_r != 8'd0) ? crem_r - 8'd1 : 8'd0;

    case (mode_r)
      M_EXPECT: begin
        win_nxt  = win_sh;
        step_nxt = step_r + 6'd1;
        if (step_r >= 6'd3) begin
          step_nxt = 6'd0;
          res_v    = 1'b1;
          res_id   = ID_START;
          res_val  = {1'b0, win_sh};
          res_kind = 5'd0;
          if (win_sh == START_WORD) begin
            mode_nxt = M_HEADER;
            win_nxt  = '1;
          end else begin
            res_err  = ERR_START;
            mode_nxt = M_SEARCH;
          end
        end
      end
      M_SEARCH: begin
        win_nxt = win_sh;
        if (win_sh == START_WORD) begin
          res_v    = 1'b1;
          res_id   = ID_START;
          res_val  = {1'b0, START_WORD};
          res_kind = 5'd0;
          mode_nxt = M_HEADER;
          win_nxt  = '1;
        end
      end
      M_HEADER: begin
        res_v    = 1'b1;
        res_kind = t;
        case (cmd.cnt)
          3'd0: begin
            utype_nxt = t;
            res_id    = ID_FORBIDDEN;
            res_val   = {32'd0, byte_r[7]};
          end
          3'd1: begin
            res_id  = ID_REF_IDC;
            res_val = {31'd0, byte_r[6:5]};
          end
          default: begin
            res_id    = ID_UNIT_TYPE;
            res_val   = {28'd0, t};
            res_err   = (t == 5'd0 || t > AUD_TYPE) ? ERR_UNKNOWN : ERR_NONE;
            acc_nxt   = '0;
            taken_nxt = '0;
            zc_nxt    = '0;
            if (t == AUD_TYPE) begin
              mode_nxt = M_SKIP;
            end else if (t == SPS_TYPE) begin
              mode_nxt = M_SPS;
              step_nxt = ID_PROFILE;
            end else if (t >= 5'd1 && t <= 5'd5) begin
              mode_nxt = M_SLICE;
              step_nxt = ID_FIRST_MB;
            end else begin
              srch = 1'b1;
            end
          end
        endcase
      end
      M_SPS, M_SLICE: begin
        if (kind < KIND_UE) begin
          acc_nxt   = acc_sh;
          taken_nxt = taken_inc;
          if (taken_inc >= kind) begin
            cmp_en  = 1'b1;
            cmp_val = acc_sh;
          end
        end else if (acc_r == 33'd0) begin
          if (!bit_in) begin
            zc_nxt = zc_inc;
            if (zc_inc > 6'(MAX_GOLOMB_ZEROS)) begin
              res_v   = 1'b1;
              res_err = ERR_GOLOMB;
              srch    = 1'b1;
            end
          end else if (zc_r == 6'd0) begin
            cmp_en = 1'b1;
          end else begin
            acc_nxt = 33'd1;
          end
        end else begin
          acc_nxt   = acc_sh;
          taken_nxt = taken_inc;
          if (taken_inc >= zc_r) begin
            cmp_en = 1'b1;
            if (kind == KIND_SE) begin
              // odd codes map to positive values, even codes to zero and negative values
              if (code[0]) cmp_val = (code + 33'd1) >> 1;
              else         cmp_val = ~(code >> 1) + 33'd1;
            end else begin
              cmp_val = code;
            end
          end
        end
      end
      M_SKIP: begin
        mode_nxt = M_EXPECT;
        step_nxt = 6'd0;
        win_nxt  = '1;
      end
      default: srch = 1'b1;
    endcase

    if (cmp_en) begin
      res_v     = 1'b1;
      res_id    = step_r;
      res_val   = cmp_val;
      res_idx   = (step_r == ID_OFFSET_REF) ? cidx_r : 8'd0;
      res_kind  = utype_r;
      res_err   = ERR_NONE;
      acc_nxt   = '0;
      taken_nxt = '0;
      zc_nxt    = '0;
      case (step_r)
        ID_PROFILE: prof_nxt = cmp_val[7:0];
        ID_SPS_ID:  nxt_id = (prof_r == HIGH_PROFILE) ? {1'b0, ID_CHROMA} : {1'b0, ID_LOG2_FN};
        ID_POC_TYPE: begin
          if (cmp_val == 33'd0) begin
            poc_nxt = 2'd0;
            nxt_id  = {1'b0, ID_LOG2_POC};
          end else if (cmp_val == 33'd1) begin
            poc_nxt = 2'd1;
            nxt_id  = {1'b0, ID_DELTA_ZERO};
          end else begin
            poc_nxt = 2'd2;
            nxt_id  = {1'b0, ID_NUM_REF};
          end
        end
        ID_LOG2_POC: nxt_id = {1'b0, ID_NUM_REF};
        ID_NUM_CYCLE: begin
          crem_nxt = (cmp_val > 33'(MAX_POC_CYCLE)) ? 8'(MAX_POC_CYCLE) : cmp_val[7:0];
          cidx_nxt = 8'd0;
          nxt_id   = (crem_nxt == 8'd0) ? {1'b0, ID_NUM_REF} : {1'b0, ID_OFFSET_REF};
        end
        ID_OFFSET_REF: begin
          cidx_nxt = cidx_r + 8'd1;
          crem_nxt = crem_dec;
          nxt_id   = (crem_dec == 8'd0) ? {1'b0, ID_NUM_REF} : {1'b0, ID_OFFSET_REF};
        end
        ID_FRAME_MBS: begin
          flags_nxt = {flags_r[1], cmp_val[0]};
          nxt_id    = cmp_val[0] ? {1'b0, ID_DIRECT_8X8} : {1'b0, ID_MB_AFF};
        end
        ID_CROPPING: begin
          flags_nxt = {cmp_val[0], flags_r[0]};
          nxt_id    = cmp_val[0] ? {1'b0, ID_CROP_LEFT} : {1'b0, ID_VUI};
        end
        ID_VUI, ID_PPS_ID: nxt_id = {1'b0, NUM_IDS};
        default: ;
      endcase
      if (nxt_id >= {1'b0, NUM_IDS}) srch = 1'b1;
      else                           step_nxt = nxt_id[5:0];
    end

    if (srch) begin
      mode_nxt  = M_SEARCH;
      win_nxt   = '1;
      acc_nxt   = '0;
      taken_nxt = '0;
      zc_nxt    = '0;
    end

    case (mode_r)
      M_HEADER:       last_step = (cmd.cnt == 3'd2);
      M_SPS, M_SLICE: last_step = (cmd.cnt == 3'd7) ||
                                  (mode_nxt != M_SPS && mode_nxt != M_SLICE);
      default:        last_step = 1'b1;
    endcase
  end

  // parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= M_EXPECT;
      step_r  <= '0;
      win_r   <= '1;
      acc_r   <= '0;
      taken_r <= '0;
      zc_r    <= '0;
      utype_r <= '0;
      prof_r  <= '0;
      poc_r   <= '0;
      crem_r  <= '0;
      cidx_r  <= '0;
      flags_r <= '0;
    end else if (cmd.step) begin
      mode_r  <= mode_nxt;
      step_r  <= step_nxt;
      win_r   <= win_nxt;
      acc_r   <= acc_nxt;
      taken_r <= taken_nxt;
      zc_r    <= zc_nxt;
      utype_r <= utype_nxt;
      prof_r  <= prof_nxt;
      poc_r   <= poc_nxt;
      crem_r  <= crem_nxt;
      cidx_r  <= cidx_nxt;
      flags_r <= flags_nxt;
    end else if (cmd.flush && end_r) begin
      // end of buffer abandons the unit
      mode_r  <= M_EXPECT;
      step_r  <= '0;
      win_r   <= '1;
      acc_r   <= '0;
      taken_r <= '0;
      zc_r    <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      byte_r <= in_byte;
      end_r  <= in_end;
    end
  end

  // pending word holds back the newest result until its last flag is known
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (cmd.step && res_v) begin
        if (pend_v_r) begin
          out_v_r    <= 1'b1;
          out_id_r   <= pend_id_r;
          out_val_r  <= pend_val_r;
          out_idx_r  <= pend_idx_r;
          out_kind_r <= pend_kind_r;
          out_err_r  <= pend_err_r;
          out_last_r <= 1'b0;
        end else if (out_rdy) begin
          out_v_r <= 1'b0;
        end
        pend_v_r    <= 1'b1;
        pend_id_r   <= res_id;
        pend_val_r  <= res_val;
        pend_idx_r  <= res_idx;
        pend_kind_r <= res_kind;
        pend_err_r  <= res_err;
      end else if (cmd.flush && pend_v_r) begin
        out_v_r    <= 1'b1;
        out_id_r   <= pend_id_r;
        out_val_r  <= pend_val_r;
        out_idx_r  <= pend_idx_r;
        out_kind_r <= pend_kind_r;
        out_err_r  <= pend_err_r;
        out_last_r <= 1'b1;
        pend_v_r   <= 1'b0;
      end else if (out_rdy) begin
        out_v_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hdl/h264nal_checker.sv
// port-level checks of the parser and their bind to the top level
`default_nettype none
module h264nal_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_tvalid,
  input wire        out_tready,
  input wire [55:0] out_tdata,
  input wire [4:0]  out_tuser
);
  import h264nal_pkg::*;

  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("result word changed while stalled");

  a_start_err: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[48:47] == ERR_START |-> out_tdata[5:0] == ID_START
      && out_tuser == 5'd0)
    else $error("start code error on a non start code element");

  a_id_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[5:0] < NUM_IDS)
    else $error("element id out of range");

  a_index_only_ref: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[46:39] != 8'd0 |-> out_tdata[5:0] == ID_OFFSET_REF)
    else $error("index set on an element without a list");

endmodule

bind h264_nal_header_parser h264nal_checker u_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
